### sv/qau_pkg.sv
package qau_pkg;

	localparam int FRAC_BITS_DEF  = 13;
	localparam int COMP_WIDTH_DEF = 16;

	typedef enum logic [1:0] {
		ACT_MUL  = 2'd0,
		ACT_CONJ = 2'd1,
		ACT_NORM = 2'd2,
		ACT_LEN  = 2'd3
	} action_t;

endpackage

### sv/quaternion_arithmetic_unit_core.sv
// Quaternion unit, signed fixed point (COMP_WIDTH bits, FRAC_BITS fraction bits).
// Request channel (req_valid/req_ready): action plus quaternions a and b.
// Response channel (rsp_valid/rsp_ready): r_w..r_z, magnitude, overflow.
// Actions: multiply a*b, conjugate a, normalize a, length of a.
// Every transfer passes through the same pipeline: two product/sum stages,
// one square-root cell per root bit (COMP_WIDTH+1 cells), one length stage,
// one division cell per quotient bit in each of four lanes (FRAC_BITS+1
// cells per lane), then the output register.
// Throughput is one transfer per cycle while the receiver does not stall.
// The whole pipeline advances together; req_ready is high when the output
// register is empty or is taken in the same cycle. When the receiver
// stalls, the pipeline holds and req_ready drops.
// Asynchronous reset clears all valid bits; payload registers are not reset.
// The block keeps no state between transfers.
module quaternion_arithmetic_unit_core #(
	parameter int FRAC_BITS  = qau_pkg::FRAC_BITS_DEF,
	parameter int COMP_WIDTH = qau_pkg::COMP_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_ready,
	input  logic [1:0]                   action,
	input  logic signed [COMP_WIDTH-1:0] a_w,
	input  logic signed [COMP_WIDTH-1:0] a_x,
	input  logic signed [COMP_WIDTH-1:0] a_y,
	input  logic signed [COMP_WIDTH-1:0] a_z,
	input  logic signed [COMP_WIDTH-1:0] b_w,
	input  logic signed [COMP_WIDTH-1:0] b_x,
	input  logic signed [COMP_WIDTH-1:0] b_y,
	input  logic signed [COMP_WIDTH-1:0] b_z,
	output logic                         rsp_valid,
	input  logic                         rsp_ready,
	output logic signed [COMP_WIDTH-1:0] r_w,
	output logic signed [COMP_WIDTH-1:0] r_x,
	output logic signed [COMP_WIDTH-1:0] r_y,
	output logic signed [COMP_WIDTH-1:0] r_z,
	output logic [COMP_WIDTH-1:0]        magnitude,
	output logic                         overflow
);

	localparam int CW  = COMP_WIDTH;
	localparam int F   = FRAC_BITS;
	localparam int PW  = 2 * CW + 2;
	localparam int SW  = 2 * CW + 1;
	localparam int RW  = CW + 1;
	localparam int LW  = CW + 1;
	localparam int SQN = CW + 1;
	localparam int QB  = F + 1;
	localparam int NW  = CW + F + 1;
	localparam int XW  = ((QB > CW) ? QB : CW) + 1;
	localparam int NV  = 2 + SQN + 1 + QB;

	localparam logic signed [PW:0] MUL_HI = $signed({{(PW-CW+2){1'b0}}, {(CW-1){1'b1}}});
	localparam logic signed [PW:0] MUL_LO = ~MUL_HI;
	localparam logic signed [PW:0] RND    = (PW+1)'(1) << (F - 1);
	localparam logic [CW-1:0] S_HI   = {1'b0, {(CW-1){1'b1}}};
	localparam logic [CW-1:0] S_LO   = {1'b1, {(CW-1){1'b0}}};
	localparam logic          ID_OVF = (F >= CW - 1);
	localparam logic [CW-1:0] ID_W   = ID_OVF ? S_HI : (CW'(1) << F);
	localparam logic [XW-1:0] N_HI   = XW'({(CW-1){1'b1}});

	logic adv;
	logic [NV-1:0] vld_q;
	logic rsp_valid_q;

	assign adv       = !rsp_valid_q || rsp_ready;
	assign req_ready = adv;
	assign rsp_valid = rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			vld_q       <= {vld_q[NV-2:0], req_valid};
			rsp_valid_q <= vld_q[NV-1];
		end
	end

	// stage 1: products and squares
	logic signed [CW-1:0] ain [4];
	logic signed [CW-1:0] bin [4];
	qau_pkg::action_t act_s1;
	logic signed [CW-1:0] a_s1 [4];
	logic signed [2*CW-1:0] p_s1 [4][4];
	logic signed [2*CW-1:0] sq_s1 [4];

	assign ain[0] = a_w;
	assign ain[1] = a_x;
	assign ain[2] = a_y;
	assign ain[3] = a_z;
	assign bin[0] = b_w;
	assign bin[1] = b_x;
	assign bin[2] = b_y;
	assign bin[3] = b_z;

	always_ff @(posedge clk) begin
		if (adv) begin
			act_s1 <= qau_pkg::action_t'(action);
			for (int i = 0; i < 4; i++) begin
				a_s1[i]  <= ain[i];
				sq_s1[i] <= ain[i] * ain[i];
				for (int j = 0; j < 4; j++) begin
					p_s1[i][j] <= ain[i] * bin[j];
				end
			end
		end
	end

	// stage 2: Hamilton sums and sum of squares
	logic signed [PW-1:0] t_s2 [4];
	logic [SW-1:0] sum_s2;
	qau_pkg::action_t act_s2;
	logic signed [CW-1:0] a_s2 [4];

	always_ff @(posedge clk) begin
		if (adv) begin
			act_s2 <= act_s1;
			a_s2   <= a_s1;
			t_s2[0] <= PW'(p_s1[0][0]) - PW'(p_s1[1][1]) - PW'(p_s1[2][2]) - PW'(p_s1[3][3]);
			t_s2[1] <= PW'(p_s1[0][1]) + PW'(p_s1[1][0]) + PW'(p_s1[2][3]) - PW'(p_s1[3][2]);
			t_s2[2] <= PW'(p_s1[0][2]) - PW'(p_s1[1][3]) + PW'(p_s1[2][0]) + PW'(p_s1[3][1]);
			t_s2[3] <= PW'(p_s1[0][3]) + PW'(p_s1[1][2]) - PW'(p_s1[2][1]) + PW'(p_s1[3][0]);
			sum_s2 <= SW'($unsigned(sq_s1[0])) + SW'($unsigned(sq_s1[1]))
				+ SW'($unsigned(sq_s1[2])) + SW'($unsigned(sq_s1[3]));
		end
	end

	// round and saturate the product, or conjugate
	logic [CW-1:0] rp_c [4];
	logic ovfp_c;
	logic signed [PW:0] tr [4];
	logic [3:0] osat;

	always_comb begin
		osat = '0;
		for (int i = 0; i < 4; i++) begin
			tr[i] = ((PW+1)'(t_s2[i]) + RND) >>> F;
			rp_c[i] = tr[i][CW-1:0];
		end
		if (act_s2 == qau_pkg::ACT_MUL) begin
			for (int i = 0; i < 4; i++) begin
				if (tr[i] > MUL_HI) begin
					rp_c[i] = S_HI;
					osat[i] = 1'b1;
				end else if (tr[i] < MUL_LO) begin
					rp_c[i] = S_LO;
					osat[i] = 1'b1;
				end
			end
		end else if (act_s2 == qau_pkg::ACT_CONJ) begin
			rp_c[0] = a_s2[0];
			for (int i = 1; i < 4; i++) begin
				if (a_s2[i] == S_LO) begin
					rp_c[i] = S_HI;
					osat[i] = 1'b1;
				end else begin
					rp_c[i] = CW'(0) - a_s2[i];
				end
			end
		end
		ovfp_c = |osat;
	end

	// square root chain
	logic [SW-1:0] srem [SQN+1];
	logic [RW-1:0] sroot [SQN+1];
	qau_pkg::action_t act_sq_q [SQN];
	logic signed [CW-1:0] a_sq_q [SQN][4];
	logic [CW-1:0] rp_sq_q [SQN][4];
	logic ovf_sq_q [SQN];

	assign srem[0]  = sum_s2;
	assign sroot[0] = '0;

	for (genvar k = 0; k < SQN; k++) begin : g_sq
		qau_sqrt_cell #(.SW(SW), .RW(RW), .BIT(CW - k)) u_cell (
			.clk      (clk),
			.en       (adv),
			.rem      (srem[k]),
			.root     (sroot[k]),
			.nxt_rem  (srem[k+1]),
			.nxt_root (sroot[k+1])
		);
		if (k == 0) begin : g_head
			always_ff @(posedge clk) begin
				if (adv) begin
					act_sq_q[0] <= act_s2;
					a_sq_q[0]   <= a_s2;
					rp_sq_q[0]  <= rp_c;
					ovf_sq_q[0] <= ovfp_c;
				end
			end
		end else begin : g_body
			always_ff @(posedge clk) begin
				if (adv) begin
					act_sq_q[k] <= act_sq_q[k-1];
					a_sq_q[k]   <= a_sq_q[k-1];
					rp_sq_q[k]  <= rp_sq_q[k-1];
					ovf_sq_q[k] <= ovf_sq_q[k-1];
				end
			end
		end
	end

	// stage 3: round length, set up division
	logic [LW-1:0] len_c;
	logic [CW-1:0] absv [4];
	logic [NW-1:0] num [4];

	always_comb begin
		len_c = sroot[SQN] + LW'(srem[SQN] > SW'(sroot[SQN]));
		for (int i = 0; i < 4; i++) begin
			absv[i] = a_sq_q[SQN-1][i][CW-1] ? (CW'(0) - a_sq_q[SQN-1][i])
				: a_sq_q[SQN-1][i];
			num[i] = (NW'(absv[i]) << F) + NW'(len_c >> 1);
		end
	end

	qau_pkg::action_t act_s3;
	logic [LW-1:0] len_s3;
	logic [CW-1:0] mag_s3;
	logic ovf_s3;
	logic zero_s3;
	logic [3:0] sgn_s3;
	logic [CW-1:0] rp_s3 [4];
	logic [LW-1:0] rem_s3 [4];
	logic [QB-1:0] nq_s3 [4];

	always_ff @(posedge clk) begin
		if (adv) begin
			act_s3  <= act_sq_q[SQN-1];
			len_s3  <= len_c;
			mag_s3  <= len_c[CW] ? '1 : len_c[CW-1:0];
			ovf_s3  <= ovf_sq_q[SQN-1] | (len_c[CW]
				& (act_sq_q[SQN-1] == qau_pkg::ACT_NORM
				|| act_sq_q[SQN-1] == qau_pkg::ACT_LEN));
			zero_s3 <= (len_c == '0);
			rp_s3   <= rp_sq_q[SQN-1];
			for (int i = 0; i < 4; i++) begin
				sgn_s3[i] <= a_sq_q[SQN-1][i][CW-1];
				rem_s3[i] <= LW'(num[i][NW-1:QB]);
				nq_s3[i]  <= num[i][QB-1:0];
			end
		end
	end

	// division chain, four lanes sharing one divisor
	logic [LW-1:0] drem [QB+1][4];
	logic [QB-1:0] dnq [QB+1][4];
	logic [LW-1:0] len_dv [QB+1];
	qau_pkg::action_t act_dv_q [QB];
	logic [CW-1:0] mag_dv_q [QB];
	logic ovf_dv_q [QB];
	logic zero_dv_q [QB];
	logic [3:0] sgn_dv_q [QB];
	logic [CW-1:0] rp_dv_q [QB][4];

	assign len_dv[0] = len_s3;
	assign drem[0]   = rem_s3;
	assign dnq[0]    = nq_s3;

	for (genvar k = 0; k < QB; k++) begin : g_dv
		for (genvar c = 0; c < 4; c++) begin : g_lane
			qau_div_cell #(.LW(LW), .QB(QB)) u_cell (
				.clk     (clk),
				.en      (adv),
				.len     (len_dv[k]),
				.rem     (drem[k][c]),
				.nq      (dnq[k][c]),
				.nxt_rem (drem[k+1][c]),
				.nxt_nq  (dnq[k+1][c])
			);
		end
		logic [LW-1:0] len_q;
		always_ff @(posedge clk) begin
			if (adv) begin
				len_q <= len_dv[k];
			end
		end
		assign len_dv[k+1] = len_q;
		if (k == 0) begin : g_head
			always_ff @(posedge clk) begin
				if (adv) begin
					act_dv_q[0]  <= act_s3;
					mag_dv_q[0]  <= mag_s3;
					ovf_dv_q[0]  <= ovf_s3;
					zero_dv_q[0] <= zero_s3;
					sgn_dv_q[0]  <= sgn_s3;
					rp_dv_q[0]   <= rp_s3;
				end
			end
		end else begin : g_body
			always_ff @(posedge clk) begin
				if (adv) begin
					act_dv_q[k]  <= act_dv_q[k-1];
					mag_dv_q[k]  <= mag_dv_q[k-1];
					ovf_dv_q[k]  <= ovf_dv_q[k-1];
					zero_dv_q[k] <= zero_dv_q[k-1];
					sgn_dv_q[k]  <= sgn_dv_q[k-1];
					rp_dv_q[k]   <= rp_dv_q[k-1];
				end
			end
		end
	end

	// final select
	logic [XW-1:0] qx [4];
	logic [XW-1:0] qn [4];
	logic [CW-1:0] nr [4];
	logic [3:0] nsat;
	logic [CW-1:0] fr [4];
	logic [CW-1:0] fmag;
	logic fovf;
	qau_pkg::action_t fact;

	always_comb begin
		fact = act_dv_q[QB-1];
		nsat = '0;
		for (int i = 0; i < 4; i++) begin
			qx[i] = XW'(dnq[QB][i]);
			qn[i] = XW'(0) - qx[i];
			if (sgn_dv_q[QB-1][i]) begin
				if (qx[i] > N_HI + XW'(1)) begin
					nr[i]   = S_LO;
					nsat[i] = 1'b1;
				end else begin
					nr[i] = qn[i][CW-1:0];
				end
			end else begin
				if (qx[i] > N_HI) begin
					nr[i]   = S_HI;
					nsat[i] = 1'b1;
				end else begin
					nr[i] = qx[i][CW-1:0];
				end
			end
		end
		unique case (fact)
			qau_pkg::ACT_MUL, qau_pkg::ACT_CONJ: begin
				fr   = rp_dv_q[QB-1];
				fmag = '0;
				fovf = ovf_dv_q[QB-1];
			end
			qau_pkg::ACT_NORM: begin
				fmag = mag_dv_q[QB-1];
				if (zero_dv_q[QB-1]) begin
					fr[0] = ID_W;
					fr[1] = '0;
					fr[2] = '0;
					fr[3] = '0;
					fovf  = ID_OVF | ovf_dv_q[QB-1];
				end else begin
					fr   = nr;
					fovf = ovf_dv_q[QB-1] | (|nsat);
				end
			end
			default: begin
				fr[0] = '0;
				fr[1] = '0;
				fr[2] = '0;
				fr[3] = '0;
				fmag  = mag_dv_q[QB-1];
				fovf  = ovf_dv_q[QB-1];
			end
		endcase
	end

	logic [CW-1:0] r_q [4];
	logic [CW-1:0] mag_q;
	logic ovf_q;
	qau_pkg::action_t act_out_q;

	always_ff @(posedge clk) begin
		if (adv) begin
			r_q       <= fr;
			mag_q     <= fmag;
			ovf_q     <= fovf;
			act_out_q <= fact;
		end
	end

	assign r_w       = r_q[0];
	assign r_x       = r_q[1];
	assign r_y       = r_q[2];
	assign r_z       = r_q[3];
	assign magnitude = mag_q;
	assign overflow  = ovf_q;

	a_len_zero_comp: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && act_out_q == qau_pkg::ACT_LEN
		|-> r_w == '0 && r_x == '0 && r_y == '0 && r_z == '0)
		else $error("length result carries nonzero components");

	a_mag_unused: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (act_out_q == qau_pkg::ACT_MUL || act_out_q == qau_pkg::ACT_CONJ)
		|-> magnitude == '0)
		else $error("magnitude set for multiply or conjugate");

	a_norm_identity: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && act_out_q == qau_pkg::ACT_NORM && magnitude == '0
		|-> r_w == ID_W && r_x == '0 && r_y == '0 && r_z == '0)
		else $error("zero-length normalize is not the identity");

endmodule

### sv/qau_sqrt_cell.sv
module qau_sqrt_cell #(
	parameter int SW  = 2 * qau_pkg::COMP_WIDTH_DEF + 1,
	parameter int RW  = qau_pkg::COMP_WIDTH_DEF + 1,
	parameter int BIT = 0
) (
	input  logic          clk,
	input  logic          en,
	input  logic [SW-1:0] rem,
	input  logic [RW-1:0] root,
	output logic [SW-1:0] nxt_rem,
	output logic [RW-1:0] nxt_root
);

	logic [SW:0]   d;
	logic [SW:0]   diff;
	logic          ge;
	logic [SW-1:0] rem_q;
	logic [RW-1:0] root_q;

	always_comb begin
		d    = ((SW+1)'(root) << (BIT + 1)) + ((SW+1)'(1) << (2 * BIT));
		diff = {1'b0, rem} - d;
		ge   = ({1'b0, rem} >= d);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q  <= ge ? diff[SW-1:0] : rem;
			root_q <= ge ? (root | (RW'(1) << BIT)) : root;
		end
	end

	assign nxt_rem  = rem_q;
	assign nxt_root = root_q;

endmodule

### sv/qau_div_cell.sv
module qau_div_cell #(
	parameter int LW = qau_pkg::COMP_WIDTH_DEF + 1,
	parameter int QB = qau_pkg::FRAC_BITS_DEF + 1
) (
	input  logic          clk,
	input  logic          en,
	input  logic [LW-1:0] len,
	input  logic [LW-1:0] rem,
	input  logic [QB-1:0] nq,
	output logic [LW-1:0] nxt_rem,
	output logic [QB-1:0] nxt_nq
);

	logic [LW:0]   t;
	logic [LW:0]   diff;
	logic          ge;
	logic [LW-1:0] rem_q;
	logic [QB-1:0] nq_q;

	always_comb begin
		t    = {rem, nq[QB-1]};
		diff = t - {1'b0, len};
		ge   = (t >= {1'b0, len});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q <= ge ? diff[LW-1:0] : t[LW-1:0];
			nq_q  <= {nq[QB-2:0], ge};
		end
	end

	assign nxt_rem = rem_q;
	assign nxt_nq  = nq_q;

endmodule
